>>> rtl/ude_pkg.sv
// ----------------------------------------------------------------------------
// ude_pkg
// Shared types and constants for the Ulam distance engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ude_pkg;

    // default table depth
    localparam int MAX_LEN_DEFAULT = 64;

    // fixed field widths
    localparam int SYM_W  = 7;
    localparam int LEN_W  = 7;
    localparam int DIST_W = 6;
    localparam int CFG_W  = 7;

    // distance saturation value
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // command codes
    localparam logic CMD_REFERENCE = 1'b0;
    localparam logic CMD_QUERY     = 1'b1;

    // configuration register indexes
    localparam logic CFG_PERM_LENGTH  = 1'b0;
    localparam logic CFG_MIN_DISTANCE = 1'b1;

    // reset values of configuration registers
    localparam logic [LEN_W-1:0]  PERM_LENGTH_RESET  = 7'd64;
    localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 6'd1;

    // control of the shared compare unit
    typedef struct packed {
        logic clear;
        logic step;
    } lis_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/ude_lis_unit.sv
// ----------------------------------------------------------------------------
// ude_lis_unit
// Shared compare unit: folds one earlier query entry per cycle into the
// running LIS length of the current query symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module ude_lis_unit
    import ude_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lis_ctrl_t                     ctrl,
    input  wire logic [SYM_W-1:0]              mapped,
    input  wire logic [SYM_W-1:0]              entry_mapped,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]  entry_len,
    output logic      [$clog2(MAX_LEN+1)-1:0]  lis_len
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;
    logic [CNT_W-1:0] cand;

    // candidate length through this entry
    assign cand = CNT_W'(entry_len + 1'b1);

    always_comb
    begin
        len_next = len_reg;
        if (ctrl.clear)
        begin
            len_next = CNT_W'(1);
        end
        else if (ctrl.step && (entry_mapped < mapped) && (cand > len_reg))
        begin
            len_next = cand;
        end
    end

    // running length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= CNT_W'(1);
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    assign lis_len = len_reg;

endmodule

`default_nettype wire

>>> rtl/ude_result.sv
// ----------------------------------------------------------------------------
// ude_result
// Forms the distance and threshold flag at the end of a query, raises done
// for one cycle and holds the results until the next query ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ude_result
    import ude_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [LEN_W-1:0]              eff_len,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]  best_len,
    input  wire logic [DIST_W-1:0]             min_distance,
    output logic                               done,
    output logic      [DIST_W-1:0]             distance,
    output logic                               far_enough
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int DW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [DW-1:0]     n_ext;
    logic [DW-1:0]     best_ext;
    logic [DW-1:0]     dist_full;
    logic [DIST_W-1:0] shown;
    logic              far;

    logic              done_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              far_reg;

    // unsaturated distance, saturated copy and threshold compare
    always_comb
    begin
        n_ext     = DW'(eff_len);
        best_ext  = DW'(best_len);
        dist_full = (n_ext > best_ext) ? DW'(n_ext - best_ext) : '0;
        shown     = (dist_full > DW'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];
        far       = (dist_full >= DW'(min_distance));
    end

    // strobe and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            distance_reg <= shown;
            far_reg      <= far;
        end
    end

    assign done       = done_reg;
    assign distance   = distance_reg;
    assign far_enough = far_reg;

endmodule

`default_nettype wire

>>> rtl/ulam_distance_engine.sv
// ----------------------------------------------------------------------------
// ulam_distance_engine
// Ulam distance between two permutations, via the longest increasing
// subsequence of the query mapped through the reference position table.
// ----------------------------------------------------------------------------
//
//  channel   signals                                 handshake
//  -------   -------------------------------------   ---------------------------
//  request   start, busy, cmd, symbol                taken when start & !busy
//  result    done, distance, far_enough              one-cycle strobe on done
//  config    cfg_valid, cfg_ready, cfg_index,        taken when valid & ready,
//            cfg_data                                ready is always high
//
//  A reference symbol is accepted without raising busy.
//  A query symbol holds busy high while the compare unit reads each earlier
//  query entry, one per cycle, from the single read port of the query store.
//  The result strobe comes in the cycle after the last query symbol's work.
//  Reset clears control state only; the tables need no clearing pass.
//  The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
`default_nettype none

module ulam_distance_engine
    import ude_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              cmd,
    input  wire logic [SYM_W-1:0]  symbol,
    // result
    output logic                   done,
    output logic      [DIST_W-1:0] distance,
    output logic                   far_enough,
    // configuration
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int DW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int ENT_W = SYM_W + CNT_W;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [LEN_W-1:0]  perm_length_reg;
    logic [DIST_W-1:0] min_distance_reg;

    // control registers
    logic [LEN_W-1:0]  ref_idx_reg;
    logic [CNT_W-1:0]  query_idx_reg;
    logic [CNT_W-1:0]  best_reg;
    logic [IDX_W-1:0]  qi_reg;
    logic [IDX_W-1:0]  j_reg;
    logic              rd_valid_reg;
    logic              in_table_reg;

    // memories and their read registers
    logic [SYM_W-1:0]  pos_table [MAX_LEN];
    logic [ENT_W-1:0]  store_mem [MAX_LEN];
    logic [SYM_W-1:0]  pos_rd_reg;
    logic [ENT_W-1:0]  st_rd_reg;

    // combinational
    logic              accept;
    logic              accept_ref;
    logic              accept_query;
    logic              sym_in_table;
    logic [IDX_W-1:0]  sym_idx;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  ref_start;
    logic [LEN_W-1:0]  ref_pos;
    logic [LEN_W-1:0]  ref_idx_next;
    logic [IDX_W-1:0]  qi_w;
    logic              scan;
    logic              issue;
    logic              finish;
    logic [IDX_W-1:0]  rd_addr;
    logic [SYM_W-1:0]  mapped;
    logic [CNT_W-1:0]  lis_len;
    logic [CNT_W-1:0]  best_next;
    logic [CNT_W-1:0]  qcount;
    logic              last;
    lis_ctrl_t         lis_ctrl;

    // request decode
    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign accept_ref   = accept && (cmd == CMD_REFERENCE);
    assign accept_query = accept && (cmd == CMD_QUERY);
    assign sym_in_table = (symbol != '0) && (32'(symbol) <= MAX_LEN);
    assign sym_idx      = IDX_W'(symbol - 1'b1);

    // effective permutation length, clamped to 1..MAX_LEN
    always_comb
    begin
        if (perm_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(perm_length_reg) > MAX_LEN)
        begin
            eff_len = LEN_W'(MAX_LEN);
        end
        else
        begin
            eff_len = perm_length_reg;
        end
    end

    // reference position with wrap at the effective length
    assign ref_start    = (ref_idx_reg >= eff_len) ? '0 : ref_idx_reg;
    assign ref_pos      = ref_start + 1'b1;
    assign ref_idx_next = (ref_pos >= eff_len) ? '0 : ref_pos;

    // query slot, held at the last entry once the store is full
    assign qi_w = (32'(query_idx_reg) >= MAX_LEN) ? IDX_W'(MAX_LEN - 1)
                                                  : query_idx_reg[IDX_W-1:0];

    // scan sequencing
    assign scan    = (state_reg == ST_SCAN);
    assign issue   = accept_query || (scan && (j_reg < qi_reg));
    assign finish  = scan && !rd_valid_reg;
    assign rd_addr = scan ? j_reg : '0;
    assign mapped  = in_table_reg ? pos_rd_reg : '0;

    // end of query bookkeeping
    assign best_next = (lis_len > best_reg) ? lis_len : best_reg;
    assign qcount    = CNT_W'(qi_reg) + 1'b1;
    assign last      = (DW'(qcount) >= DW'(eff_len));

    // shared compare unit control
    always_comb
    begin
        lis_ctrl.clear = accept_query;
        lis_ctrl.step  = scan && rd_valid_reg;
    end

    ude_lis_unit #(
        .MAX_LEN (MAX_LEN)
    ) u_lis_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lis_ctrl),
        .mapped       (mapped),
        .entry_mapped (st_rd_reg[ENT_W-1:CNT_W]),
        .entry_len    (st_rd_reg[CNT_W-1:0]),
        .lis_len      (lis_len)
    );

    ude_result #(
        .MAX_LEN (MAX_LEN)
    ) u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (finish && last),
        .eff_len      (eff_len),
        .best_len     (best_next),
        .min_distance (min_distance_reg),
        .done         (done),
        .distance     (distance),
        .far_enough   (far_enough)
    );

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_length_reg  <= PERM_LENGTH_RESET;
            min_distance_reg <= MIN_DISTANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PERM_LENGTH:  perm_length_reg  <= cfg_data;
                CFG_MIN_DISTANCE: min_distance_reg <= cfg_data[DIST_W-1:0];
                default:          ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ref_idx_reg   <= '0;
            query_idx_reg <= '0;
            best_reg      <= '0;
            qi_reg        <= '0;
            j_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            in_table_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_ref)
                    begin
                        ref_idx_reg <= ref_idx_next;
                    end
                    else if (accept_query)
                    begin
                        state_reg    <= ST_SCAN;
                        qi_reg       <= qi_w;
                        j_reg        <= IDX_W'(1);
                        rd_valid_reg <= (qi_w != '0);
                        in_table_reg <= sym_in_table;
                    end
                end
                ST_SCAN:
                begin
                    rd_valid_reg <= issue;
                    if (issue)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    if (finish)
                    begin
                        state_reg <= ST_IDLE;
                        if (last)
                        begin
                            query_idx_reg <= '0;
                            best_reg      <= '0;
                        end
                        else
                        begin
                            query_idx_reg <= qcount;
                            best_reg      <= best_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // reference position table
    always_ff @(posedge clk)
    begin
        if (accept_ref && sym_in_table)
        begin
            pos_table[sym_idx] <= ref_pos;
        end
        if (accept_query)
        begin
            pos_rd_reg <= pos_table[sym_idx];
        end
    end

    // query store: mapped value and LIS length per query position
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            store_mem[qi_reg] <= {mapped, lis_len};
        end
        if (issue)
        begin
            st_rd_reg <= store_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
